### rtl/core/pwdc_pkg.sv
// ----------------------------------------------------------------------------
// Phase window deskew control package
// Result codes and the result record shared by the window logic and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwdc_pkg;

    localparam int unsigned OUT_BITS   = 8;
    localparam logic [7:0]  SKEW_RESET = 8'd127;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INIT_SKEW    = 3'd1,
        ST_BEFORE_REL   = 3'd2,
        ST_TAIL_LIMIT   = 3'd3,
        ST_AHEAD_LIMIT  = 3'd4,
        ST_HALTED       = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        OP_PACKET = 1'b0,
        OP_END    = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [OUT_BITS-1:0] release_count;
        logic [OUT_BITS-1:0] release_start;
        logic [OUT_BITS-1:0] store_phase;
        logic                store_valid;
        t_status             status;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/pwdc_cfg.sv
// ----------------------------------------------------------------------------
// Phase window deskew configuration register
// APB-style register file holding the max_skew register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwdc_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  o_max_skew
);

    logic [7:0] r_max_skew;
    logic       hit;

    assign hit    = (paddr[2] == 1'b0);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_skew <= pwdc_pkg::SKEW_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_max_skew <= pwdata[7:0];
        end
    end

    assign prdata     = hit ? {24'd0, r_max_skew} : 32'd0;
    assign o_max_skew = r_max_skew;

endmodule

`default_nettype wire

### rtl/core/pwdc_window.sv
// ----------------------------------------------------------------------------
// Phase window deskew window logic
// Holds the tail/head window state and computes one result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwdc_window #(
    parameter int unsigned PHASE_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_opcode,
    input  wire logic [7:0]        i_phase,
    input  wire logic [7:0]        i_max_skew,
    output pwdc_pkg::t_result      o_result
);

    localparam int unsigned WB = ((PHASE_BITS > 8) ? PHASE_BITS : 8) + 2;

    logic [PHASE_BITS-1:0] r_tail_phase, n_tail_phase;
    logic [PHASE_BITS-1:0] r_head_phase, n_head_phase;
    logic                  r_tail_known, n_tail_known;
    logic                  r_head_known, n_head_known;
    logic                  r_move_ok, n_move_ok;
    logic                  r_halted, n_halted;

    logic [WB-1:0]         phase_w, cur_w, tail_w, skew_w;
    logic [PHASE_BITS-1:0] cur;
    logic [PHASE_BITS-1:0] th, hc, tc;
    logic [PHASE_BITS-1:0] d1, d2;
    logic [WB-1:0]         mag, th_tc, th_hc, rel;
    pwdc_pkg::t_result     res;

    function automatic logic [PHASE_BITS-1:0] ring_dist(
        input logic [PHASE_BITS-1:0] a,
        input logic [PHASE_BITS-1:0] b
    );
        logic [PHASE_BITS-1:0] x, y;
        x = a - b;
        y = b - a;
        return (x < y) ? x : y;
    endfunction

    assign phase_w = WB'(i_phase);
    assign cur     = phase_w[PHASE_BITS-1:0];
    assign cur_w   = WB'(cur);
    assign tail_w  = WB'(r_tail_phase);
    assign skew_w  = WB'(i_max_skew);

    assign th    = ring_dist(r_tail_phase, r_head_phase);
    assign hc    = ring_dist(r_head_phase, cur);
    assign tc    = ring_dist(r_tail_phase, cur);
    assign d1    = r_tail_phase - cur;
    assign d2    = cur - r_tail_phase;
    assign mag   = (r_tail_phase >= cur) ? WB'(d1) : WB'(d2);
    assign th_tc = WB'(th) + WB'(tc);
    assign th_hc = WB'(th) + WB'(hc);
    assign rel   = th_hc - skew_w;

    always_comb begin
        n_tail_phase = r_tail_phase;
        n_head_phase = r_head_phase;
        n_tail_known = r_tail_known;
        n_head_known = r_head_known;
        n_move_ok    = r_move_ok;
        n_halted     = r_halted;

        res               = '0;
        res.status        = pwdc_pkg::ST_OK;
        res.store_valid   = 1'b1;
        res.store_phase   = cur_w[7:0];

        if (i_opcode == pwdc_pkg::OP_END) begin
            res.store_valid = 1'b0;
            res.store_phase = '0;
            if (r_halted) begin
                res.status = pwdc_pkg::ST_HALTED;
            end else if (r_tail_known && (i_max_skew != 8'd0)) begin
                res.release_start = tail_w[7:0];
                res.release_count = i_max_skew;
            end
            n_tail_phase = '0;
            n_head_phase = '0;
            n_tail_known = 1'b0;
            n_head_known = 1'b0;
            n_move_ok    = 1'b1;
            n_halted     = 1'b0;
        end else if (r_halted) begin
            res             = '0;
            res.status      = pwdc_pkg::ST_HALTED;
        end else if (!r_tail_known) begin
            n_tail_phase = cur;
            n_tail_known = 1'b1;
        end else if (!r_head_known) begin
            if (mag > skew_w) begin
                res        = '0;
                res.status = pwdc_pkg::ST_INIT_SKEW;
                n_halted   = 1'b1;
            end else if (r_tail_phase < cur) begin
                n_head_phase = cur;
                n_head_known = 1'b1;
            end else if (r_tail_phase > cur) begin
                n_head_phase = r_tail_phase;
                n_tail_phase = cur;
                n_head_known = 1'b1;
            end
        end else if ((WB'(hc) + WB'(tc)) > WB'(th)) begin
            if (tc < hc) begin
                if (th_tc < skew_w) begin
                    if (!r_move_ok) begin
                        res        = '0;
                        res.status = pwdc_pkg::ST_BEFORE_REL;
                        n_halted   = 1'b1;
                    end else begin
                        n_tail_phase = cur;
                    end
                end else begin
                    res        = '0;
                    res.status = pwdc_pkg::ST_TAIL_LIMIT;
                    n_halted   = 1'b1;
                end
            end else if (WB'(hc) < skew_w) begin
                if (th_hc >= skew_w) begin
                    n_move_ok = 1'b0;
                    if (rel != '0) begin
                        res.release_start = tail_w[7:0];
                    end
                    res.release_count = (rel > WB'(255)) ? 8'd255 : rel[7:0];
                    n_tail_phase      = r_tail_phase + rel[PHASE_BITS-1:0];
                end
                n_head_phase = r_head_phase + hc;
            end else begin
                res        = '0;
                res.status = pwdc_pkg::ST_AHEAD_LIMIT;
                n_halted   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_phase <= '0;
            r_head_phase <= '0;
            r_tail_known <= 1'b0;
            r_head_known <= 1'b0;
            r_move_ok    <= 1'b1;
            r_halted     <= 1'b0;
        end else if (i_valid) begin
            r_tail_phase <= n_tail_phase;
            r_head_phase <= n_head_phase;
            r_tail_known <= n_tail_known;
            r_head_known <= n_head_known;
            r_move_ok    <= n_move_ok;
            r_halted     <= n_halted;
        end
    end

    assign o_result = res;

`ifndef SYNTH
    a_halt_needs_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_tail_known)
        else $error("halted without a known tail");

    a_head_needs_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_known |-> r_tail_known)
        else $error("head known without a tail");

    a_move_lock_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_move_ok |-> r_head_known)
        else $error("tail backup locked before the head is known");

    a_fatal_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_opcode == pwdc_pkg::OP_PACKET) &&
         ((res.status == pwdc_pkg::ST_INIT_SKEW) ||
          (res.status == pwdc_pkg::ST_BEFORE_REL) ||
          (res.status == pwdc_pkg::ST_TAIL_LIMIT) ||
          (res.status == pwdc_pkg::ST_AHEAD_LIMIT))) |=> r_halted)
        else $error("fatal error did not halt the block");
`endif

endmodule

`default_nettype wire

### rtl/core/phase_window_deskew_control.sv
// An accepted item is held in the input register; its result in the output register.
// Throughput: one item per cycle unless the output stalls.
// Both stages stall only when the output register holds an untaken result.
// Reset is synchronous and active low; it clears the window state and sets
// max_skew to 127.
// ----------------------------------------------------------------------------
// Phase window deskew control
// Input register, window update logic and result register for packet phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phase_window_deskew_control #(
    parameter int unsigned PHASE_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] phase
    input  wire logic        s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [3] store_valid, [11:4] store_phase,
    // [19:12] release_start, [27:20] release_count, [31:28] zero
    output logic      [31:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic              r_in_valid;
    logic              r_in_opcode;
    logic [7:0]        r_in_phase;
    logic              r_out_valid;
    pwdc_pkg::t_result r_out_res;
    pwdc_pkg::t_result win_res;
    logic [7:0]        max_skew;
    logic              advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    pwdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_skew (max_skew)
    );

    pwdc_window #(
        .PHASE_BITS (PHASE_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (advance),
        .i_opcode   (r_in_opcode),
        .i_phase    (r_in_phase),
        .i_max_skew (max_skew),
        .o_result   (win_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_opcode <= s_axis_tuser;
            r_in_phase  <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= win_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_res.release_count, r_out_res.release_start,
                            r_out_res.store_phase, r_out_res.store_valid,
                            r_out_res.status};

endmodule

`default_nettype wire
